// ===== rtl/psga_pkg.sv =====
`default_nettype none
package psga_pkg;

	localparam int unsigned GROUP_SLOTS_DEF = 8;
	localparam logic [26:0] CUTOFF_RESET = 27'd19980902;
	localparam logic [6:0]  RATE_FULL = 7'd100;

	localparam int unsigned IN_DATA_W  = 104;
	localparam int unsigned OUT_DATA_W = 256;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic REG_CUTOFF = 1'b0;

	typedef struct packed {
		logic        vld;
		logic [15:0] key;
		logic [15:0] qty;
		logic [23:0] price;
		logic [30:0] dprice;
		logic [38:0] charge;
	} tok_t;

	typedef struct packed {
		logic [15:0] key;
		logic [31:0] qty;
		logic [47:0] base;
		logic [62:0] disc;
		logic [62:0] chg;
		logic [31:0] cnt;
	} grp_t;

	typedef struct packed {
		logic used;
		grp_t grp;
	} slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_DUMP
	} dump_state_t;

endpackage
`default_nettype wire

// ===== rtl/psga_prod.sv =====
`default_nettype none
module psga_prod
	import psga_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_vld,
	input  wire logic [26:0] ship_date,
	input  wire logic [26:0] cutoff,
	input  wire logic [15:0] key,
	input  wire logic [15:0] qty,
	input  wire logic [23:0] price,
	input  wire logic [6:0]  discount,
	input  wire logic [6:0]  tax,
	output tok_t             tok,
	output logic             busy
);

	logic        vld_s1;
	logic [15:0] key_s1;
	logic [15:0] qty_s1;
	logic [23:0] price_s1;
	logic [30:0] dprice_s1;
	logic [6:0]  tax_s1;
	logic [6:0]  disc_sat;
	logic        vld_s2;
	logic [15:0] key_s2;
	logic [15:0] qty_s2;
	logic [23:0] price_s2;
	logic [30:0] dprice_s2;
	logic [38:0] charge_s2;

	assign disc_sat = (discount > RATE_FULL) ? RATE_FULL : discount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld && (ship_date <= cutoff);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		key_s1    <= key;
		qty_s1    <= qty;
		price_s1  <= price;
		tax_s1    <= tax;
		dprice_s1 <= 31'(price * 31'(RATE_FULL - disc_sat));
		key_s2    <= key_s1;
		qty_s2    <= qty_s1;
		price_s2  <= price_s1;
		dprice_s2 <= dprice_s1;
		charge_s2 <= 39'(dprice_s1 * 39'({1'b0, RATE_FULL} + {1'b0, tax_s1}));
	end

	assign tok  = {vld_s2, key_s2, qty_s2, price_s2, dprice_s2, charge_s2};
	assign busy = vld_s1 | vld_s2;

endmodule
`default_nettype wire

// ===== rtl/psga_cell.sv =====
`default_nettype none
module psga_cell
	import psga_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tok_t tok_in,
	output tok_t      tok_out,
	input  wire logic shift,
	input  wire slot_t slot_in,
	output slot_t     slot_out
);

	logic        used_q;
	grp_t        grp_q;
	logic        tok_vld_q;
	logic [15:0] tok_key_q;
	logic [15:0] tok_qty_q;
	logic [23:0] tok_price_q;
	logic [30:0] tok_dprice_q;
	logic [38:0] tok_charge_q;
	logic        hit;
	logic        take;

	assign hit  = tok_in.vld && used_q && (grp_q.key == tok_in.key);
	assign take = tok_in.vld && !used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld && !hit && !take;
			if (shift) begin
				used_q <= slot_in.used;
			end else if (take) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_key_q    <= tok_in.key;
		tok_qty_q    <= tok_in.qty;
		tok_price_q  <= tok_in.price;
		tok_dprice_q <= tok_in.dprice;
		tok_charge_q <= tok_in.charge;
		if (shift) begin
			grp_q <= slot_in.grp;
		end else if (take) begin
			grp_q.key  <= tok_in.key;
			grp_q.qty  <= 32'(tok_in.qty);
			grp_q.base <= 48'(tok_in.price);
			grp_q.disc <= 63'(tok_in.dprice);
			grp_q.chg  <= 63'(tok_in.charge);
			grp_q.cnt  <= 32'd1;
		end else if (hit) begin
			grp_q.qty  <= grp_q.qty + 32'(tok_in.qty);
			grp_q.base <= grp_q.base + 48'(tok_in.price);
			grp_q.disc <= grp_q.disc + 63'(tok_in.dprice);
			grp_q.chg  <= grp_q.chg + 63'(tok_in.charge);
			grp_q.cnt  <= grp_q.cnt + 32'd1;
		end
	end

	assign tok_out       = {tok_vld_q, tok_key_q, tok_qty_q, tok_price_q, tok_dprice_q,
		tok_charge_q};
	assign slot_out.used = used_q;
	assign slot_out.grp  = grp_q;

endmodule
`default_nettype wire

// ===== rtl/pricing_summary_group_aggregate.sv =====
`default_nettype none
// Channel   Dir  tdata                                tuser / tlast
// s_*       in   row fields, 104 bits                 tuser: kind
// m_*       out  group key and sums, 256 bits         tuser: slot_used, rows_dropped; tlast
// apb       in   ship_date_cutoff at byte address 0   -
//
// A data row is taken in every cycle while no dump is under way. It passes the
// multiplier stages s1 and s2 and then moves one slot cell per cycle down the chain.
// A dump request waits until the chain holds no row, then sends GROUP_SLOTS results
// at one per cycle while the slots shift toward the output, which leaves the table
// empty. A stall on m_tready holds the shift.
// Reset empties the table, clears the drop flag and sets the cutoff to 19980902.
module pricing_summary_group_aggregate
	import psga_pkg::*;
#(
	parameter int unsigned GROUP_SLOTS = GROUP_SLOTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// ship_date, return_flag, line_status, quantity, extended_price, discount, tax
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// kind
	input  wire logic [0:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// group_return_flag, group_line_status, sum_quantity, sum_base_price,
	// sum_disc_price, sum_charge, row_count
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// slot_used, rows_dropped
	output logic [1:0]                 m_tuser,
	output logic                       m_tlast,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int unsigned IDX_W = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

	logic [26:0]      cutoff_q;
	logic             drop_q;
	logic [IDX_W-1:0] idx_q;
	dump_state_t      state_q;
	dump_state_t      state_nxt;
	logic             shift;
	logic             prod_busy;
	logic             busy;
	logic             row_acc;
	logic             dump_acc;
	logic             dump_done;
	logic             slot_last;
	tok_t             tok [GROUP_SLOTS+1];
	slot_t            slot [GROUP_SLOTS+1];
	logic [GROUP_SLOTS-1:0] tok_live;
	grp_t             out_grp;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CUTOFF) ? {5'd0, cutoff_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CUTOFF)) begin
			cutoff_q <= pwdata[26:0];
		end
	end

	assign row_acc  = s_tvalid && s_tready && !s_tuser[0];
	assign dump_acc = s_tvalid && s_tready && s_tuser[0];

	psga_prod u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (row_acc),
		.ship_date (s_tdata[26:0]),
		.cutoff    (cutoff_q),
		.key       (s_tdata[42:27]),
		.qty       (s_tdata[58:43]),
		.price     (s_tdata[82:59]),
		.discount  (s_tdata[89:83]),
		.tax       (s_tdata[96:90]),
		.tok       (tok[0]),
		.busy      (prod_busy)
	);

	assign slot[GROUP_SLOTS] = '0;

	for (genvar i = 0; i < GROUP_SLOTS; i++) begin : g_cell
		psga_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1]),
			.shift    (shift),
			.slot_in  (slot[i+1]),
			.slot_out (slot[i])
		);
		assign tok_live[i] = tok[i+1].vld;
	end

	assign busy      = prod_busy || (|tok_live);
	assign slot_last = (idx_q == IDX_W'(GROUP_SLOTS - 1));
	assign dump_done = m_tvalid && m_tready && slot_last;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (dump_acc) state_nxt = ST_DRAIN;
			ST_DRAIN: if (!busy) state_nxt = ST_DUMP;
			ST_DUMP:  if (m_tready && slot_last) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_DRAIN: ;
			ST_DUMP:  m_tvalid = 1'b1;
			default:  ;
		endcase
	end

	assign shift = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (dump_done) begin
				idx_q <= '0;
			end else if (shift) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (dump_done) begin
				drop_q <= 1'b0;
			end else if (tok[GROUP_SLOTS].vld) begin
				drop_q <= 1'b1;
			end
		end
	end

	assign out_grp = slot[0].used ? slot[0].grp : '0;
	assign m_tdata = {2'd0, out_grp.cnt, out_grp.chg, out_grp.disc, out_grp.base,
		out_grp.qty, out_grp.key[15:8], out_grp.key[7:0]};
	assign m_tuser = {drop_q, slot[0].used};
	assign m_tlast = slot_last;

	a_no_input_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during dump");
	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid) else $error("dump overran");
	a_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !busy) else $error("row in chain during dump");
	a_table_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !slot[0].used) else $error("table not cleared");

endmodule
`default_nettype wire

// ===== verif/pricing_summary_group_aggregate_checker.sv =====
`timescale 1ns / 100ps
module pricing_summary_group_aggregate_checker
	import psga_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	// ship_date, return_flag, line_status, quantity, extended_price, discount, tax
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// kind
	input  wire logic [0:0]            s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	// group_return_flag, group_line_status, sum_quantity, sum_base_price,
	// sum_disc_price, sum_charge, row_count
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	// slot_used, rows_dropped
	input  wire logic [1:0]            m_tuser,
	input  wire logic                  m_tlast,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	input  wire logic                  pready,
	output int unsigned                fail_count,
	output int unsigned                pending
);

	localparam int unsigned SLOTS = GROUP_SLOTS_DEF;
	localparam logic [APB_ADDR_W-1:0] CUTOFF_ADDR = APB_ADDR_W'(4 * REG_CUTOFF);

	typedef struct packed {
		logic        used;
		logic [7:0]  flag;
		logic [7:0]  status;
		logic [31:0] qty;
		logic [47:0] base;
		logic [62:0] disc;
		logic [62:0] chg;
		logic [31:0] rows;
		logic        dropped;
		logic        last;
	} slot_report_t;

	logic [26:0] cutoff_date;
	logic        grp_used [SLOTS];
	logic [15:0] grp_key  [SLOTS];
	logic [31:0] grp_qty  [SLOTS];
	logic [47:0] grp_base [SLOTS];
	logic [62:0] grp_disc [SLOTS];
	logic [62:0] grp_chg  [SLOTS];
	logic [31:0] grp_rows [SLOTS];
	logic        drop_seen;
	slot_report_t slot_reports [$];
	int unsigned mismatches;

	function automatic void clear_groups();
		for (int i = 0; i < SLOTS; i++) begin
			grp_used[i] = 1'b0;
			grp_key[i]  = '0;
			grp_qty[i]  = '0;
			grp_base[i] = '0;
			grp_disc[i] = '0;
			grp_chg[i]  = '0;
			grp_rows[i] = '0;
		end
		drop_seen = 1'b0;
	endfunction

	function automatic void add_row(input logic [IN_DATA_W-1:0] row);
		logic [15:0] key;
		logic [63:0] price;
		logic [63:0] disc_rate;
		logic [63:0] tax_rate;
		logic [63:0] dprice;
		logic [63:0] charge;
		int hit;
		int free_slot;
		if (row[26:0] > cutoff_date)
			return;
		key       = {row[34:27], row[42:35]};
		price     = 64'(row[82:59]);
		disc_rate = 64'(row[89:83]);
		tax_rate  = 64'(row[96:90]);
		if (disc_rate > 64'(RATE_FULL))
			disc_rate = 64'(RATE_FULL);
		dprice = price * (64'(RATE_FULL) - disc_rate);
		charge = dprice * (64'(RATE_FULL) + tax_rate);
		hit = -1;
		free_slot = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit < 0 && grp_used[i] && grp_key[i] == key)
				hit = i;
			if (hit < 0 && !grp_used[i] && free_slot < 0)
				free_slot = i;
		end
		if (hit < 0) begin
			if (free_slot < 0) begin
				drop_seen = 1'b1;
				return;
			end
			hit = free_slot;
			grp_used[hit] = 1'b1;
			grp_key[hit]  = key;
			grp_qty[hit]  = '0;
			grp_base[hit] = '0;
			grp_disc[hit] = '0;
			grp_chg[hit]  = '0;
			grp_rows[hit] = '0;
		end
		grp_qty[hit]  = grp_qty[hit] + 32'(row[58:43]);
		grp_base[hit] = grp_base[hit] + price[47:0];
		grp_disc[hit] = grp_disc[hit] + dprice[62:0];
		grp_chg[hit]  = grp_chg[hit] + charge[62:0];
		grp_rows[hit] = grp_rows[hit] + 32'd1;
	endfunction

	function automatic void record_dump();
		slot_report_t r;
		for (int i = 0; i < SLOTS; i++) begin
			r = '0;
			if (grp_used[i]) begin
				r.used   = 1'b1;
				r.flag   = grp_key[i][15:8];
				r.status = grp_key[i][7:0];
				r.qty    = grp_qty[i];
				r.base   = grp_base[i];
				r.disc   = grp_disc[i];
				r.chg    = grp_chg[i];
				r.rows   = grp_rows[i];
			end
			r.dropped = drop_seen;
			r.last    = (i == SLOTS - 1);
			slot_reports.push_back(r);
		end
		clear_groups();
	endfunction

	function automatic int unsigned field_mismatch(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		slot_report_t want;
		if (!arst_n) begin
			cutoff_date = CUTOFF_RESET;
			clear_groups();
			slot_reports.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CUTOFF_ADDR)
				cutoff_date = pwdata[26:0];
			if (m_tvalid && m_tready) begin
				if (slot_reports.size() == 0) begin
					$error("unexpected group result, key %0h", m_tdata[15:0]);
					mismatches++;
				end else begin
					want = slot_reports.pop_front();
					mismatches += field_mismatch("slot_used", want.used, m_tuser[0]);
					mismatches += field_mismatch("group_return_flag", want.flag, m_tdata[7:0]);
					mismatches += field_mismatch("group_line_status", want.status, m_tdata[15:8]);
					mismatches += field_mismatch("sum_quantity", want.qty, m_tdata[47:16]);
					mismatches += field_mismatch("sum_base_price", want.base, m_tdata[95:48]);
					mismatches += field_mismatch("sum_disc_price", want.disc, m_tdata[158:96]);
					mismatches += field_mismatch("sum_charge", want.chg, m_tdata[221:159]);
					mismatches += field_mismatch("row_count", want.rows, m_tdata[253:222]);
					mismatches += field_mismatch("rows_dropped", want.dropped, m_tuser[1]);
					mismatches += field_mismatch("last", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0])
					record_dump();
				else
					add_row(s_tdata);
			end
			fail_count <= mismatches;
			pending <= slot_reports.size();
		end
	end

endmodule

// ===== verif/pricing_summary_group_aggregate_tb.sv =====
`timescale 1ns / 100ps
module pricing_summary_group_aggregate_tb;
	import psga_pkg::*;

	localparam int unsigned SLOTS = GROUP_SLOTS_DEF;
	localparam logic [APB_ADDR_W-1:0] CUTOFF_ADDR = APB_ADDR_W'(4 * REG_CUTOFF);
	localparam logic [26:0] DATE_MAX = 27'd99991231;
	localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 12;
	localparam logic KIND_ROW = 1'b0;
	localparam logic KIND_DUMP = 1'b1;

	typedef struct {
		logic [26:0] date;
		logic [7:0]  flag;
		logic [7:0]  status;
		logic [15:0] qty;
		logic [23:0] price;
		logic [6:0]  disc;
		logic [6:0]  tax;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	int unsigned           fail_count;
	int unsigned           pending;

	int unsigned burst_left;
	int unsigned ready_age = 0;
	int unsigned ready_mode = 0;
	logic [26:0] cur_cutoff;
	logic [15:0] key_pool [12];
	int unsigned pool_size;

	pricing_summary_group_aggregate u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	pricing_summary_group_aggregate_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (ready_age == 0) begin
			ready_mode <= $urandom_range(0, 2);
			ready_age <= $urandom_range(10, 80);
		end else begin
			ready_age <= ready_age - 1;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic row_t make_row(input logic [15:0] key, input logic [26:0] date,
			input logic [15:0] qty, input logic [23:0] price, input logic [6:0] disc,
			input logic [6:0] tax);
		row_t r;
		r.date   = date;
		r.flag   = key[15:8];
		r.status = key[7:0];
		r.qty    = qty;
		r.price  = price;
		r.disc   = disc;
		r.tax    = tax;
		return r;
	endfunction

	function automatic row_t random_row();
		row_t r;
		logic [15:0] key;
		int unsigned c;
		key = key_pool[$urandom_range(0, pool_size - 1)];
		c = cur_cutoff;
		case ($urandom_range(0, 4))
			0: r.date = 27'(c);
			1: r.date = (c > 3) ? 27'(c - $urandom_range(1, 3)) : 27'd0;
			2: r.date = 27'(c + $urandom_range(1, 3));
			3: r.date = 27'($urandom_range(0, DATE_MAX));
			default: r.date = $urandom_range(0, 1) ? DATE_MAX : 27'd0;
		endcase
		r.flag   = key[15:8];
		r.status = key[7:0];
		r.qty    = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
		r.price  = ($urandom_range(0, 4) == 0) ? 24'hFFFFFF : 24'($urandom);
		r.disc   = 7'($urandom_range(0, 127));
		r.tax    = 7'($urandom_range(0, 127));
		return r;
	endfunction

	function automatic void refresh_key_pool();
		pool_size = $urandom_range(2, 12);
		for (int i = 0; i < 12; i++)
			key_pool[i] = 16'($urandom);
	endfunction

	task automatic send_item(input logic kind, input row_t r);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_DATA_W'({r.tax, r.disc, r.price, r.qty, r.status, r.flag, r.date});
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cutoff(input logic [26:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CUTOFF_ADDR;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_cutoff = value;
	endtask

	initial begin : stimulus
		int unsigned random_items;
		int unsigned phase;
		int unsigned n;
		burst_left = 0;
		cur_cutoff = CUTOFF_RESET;
		refresh_key_pool();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(KIND_DUMP, random_row());
		send_item(KIND_ROW, make_row(16'hFF00, 27'd0, 16'hFFFF, 24'hFFFFFF, 7'd0, 7'd127));
		send_item(KIND_ROW, make_row(16'hFF00, CUTOFF_RESET, 16'hFFFF, 24'hFFFFFF, 7'd100,
			7'd0));
		send_item(KIND_ROW, make_row(16'hFF00, CUTOFF_RESET + 27'd1, 16'd5, 24'd1000, 7'd10,
			7'd10));
		send_item(KIND_ROW, make_row(16'h4146, DATE_MAX, 16'd3, 24'd500, 7'd5, 7'd5));
		send_item(KIND_ROW, make_row(16'h4146, 27'd19980231, 16'd17, 24'd123456, 7'd127,
			7'd8));
		send_item(KIND_ROW, make_row(16'h4146, 27'd19920101, 16'd1, 24'd99, 7'd101, 7'd101));
		for (int i = 0; i < SLOTS - 2; i++)
			send_item(KIND_ROW, make_row((i == 0) ? 16'h0000 : {8'h4E + 8'(i), 8'h4F},
				27'd19950101, 16'($urandom), 24'($urandom), 7'd6, 7'd2));
		send_item(KIND_ROW, make_row(16'hA5A5, 27'd19950101, 16'd9, 24'd9999, 7'd1, 7'd1));
		send_item(KIND_ROW, make_row(16'hFF00, 27'd19970704, 16'd2, 24'd4242, 7'd50, 7'd50));
		send_item(KIND_DUMP, random_row());
		send_item(KIND_DUMP, random_row());
		write_cutoff(27'd0);
		send_item(KIND_ROW, make_row(16'h5244, 27'd0, 16'd8, 24'd777, 7'd3, 7'd4));
		send_item(KIND_ROW, make_row(16'h5244, 27'd1, 16'd8, 24'd777, 7'd3, 7'd4));
		send_item(KIND_DUMP, random_row());

		random_items = 0;
		phase = 0;
		while (random_items < 340) begin
			case (phase % 4)
				0: write_cutoff(DATE_MAX);
				1: write_cutoff(27'd0);
				2: write_cutoff(CUTOFF_RESET);
				default: write_cutoff(27'($urandom_range(0, DATE_MAX)));
			endcase
			refresh_key_pool();
			n = $urandom_range(30, 70);
			for (int i = 0; i < n; i++)
				send_item(($urandom_range(0, 11) == 0) ? KIND_DUMP : KIND_ROW, random_row());
			send_item(KIND_DUMP, random_row());
			random_items += n + 1;
			phase++;
		end

		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/psga_pkg.sv
rtl/psga_prod.sv
rtl/psga_cell.sv
rtl/pricing_summary_group_aggregate.sv
verif/pricing_summary_group_aggregate_checker.sv
verif/pricing_summary_group_aggregate_tb.sv
